// ===== rtl/core/http_get_request_validator_unit_macros.svh =====
// Assertion macros shared by the request validator RTL.
`ifndef HTTP_GET_REQUEST_VALIDATOR_UNIT_MACROS_SVH
`define HTTP_GET_REQUEST_VALIDATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define HGV_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("request validator assertion failed");

// Next-cycle implication, disabled while reset is high.
`define HGV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("request validator assertion failed");

`endif

// ===== rtl/core/hgv_pkg.sv =====
// Types, constants and literal tables of the request validator.
package hgv_pkg;

   typedef enum logic [1:0] {
      PH_METHOD  = 2'd0,
      PH_URL     = 2'd1,
      PH_VERSION = 2'd2,
      PH_SKIP    = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      SEP_NONE  = 2'd0,
      SEP_COLON = 2'd1,
      SEP_FOUND = 2'd2,
      SEP_VALUE = 2'd3
   } sep_type;

   typedef struct packed {
      phase_type   phase;
      logic [3:0]  literal_index;
      logic        error_seen;
      logic [1:0]  line_number;
      sep_type     separator_progress;
      logic        key_nonempty;
      logic [2:0]  host_progress;
      logic        url_overflowed;
   } hdr_state_type;

   typedef struct packed {
      logic        carriage_return_held;
      logic [1:0]  terminator_progress;
      logic [4:0]  close_progress;
      logic        close_found;
   } strm_state_type;

   typedef struct packed {
      logic        status;
      logic        close_requested;
      logic [11:0] url_length;
      logic        url_overflow;
   } rsp_type;

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_H     = 8'h48;
   localparam logic [7:0] CHAR_C     = 8'h43;

   localparam logic [3:0]  METHOD_LEN  = 4'd3;
   localparam logic [3:0]  VERSION_LEN = 4'd8;
   localparam logic [2:0]  HOST_LEN    = 3'd4;
   localparam logic [4:0]  CLOSE_LEN   = 5'd17;
   localparam logic [1:0]  LINES_MIN   = 2'd2;
   localparam logic [11:0] OUT_URL_MAX = 12'hFFF;

   localparam hdr_state_type HDR_CLEAR = '{
      phase: PH_METHOD, literal_index: 4'd0, error_seen: 1'b0, line_number: 2'd0,
      separator_progress: SEP_NONE, key_nonempty: 1'b0, host_progress: 3'd0,
      url_overflowed: 1'b0
   };

   localparam strm_state_type STRM_CLEAR = '{
      carriage_return_held: 1'b0, terminator_progress: 2'd0, close_progress: 5'd0,
      close_found: 1'b0
   };

   function automatic logic [7:0] method_char(input logic [1:0] idx);
      case (idx)
         2'd0:    return "G";
         2'd1:    return "E";
         2'd2:    return "T";
         default: return 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] version_char(input logic [2:0] idx);
      case (idx)
         3'd0:    return "H";
         3'd1:    return "T";
         3'd2:    return "T";
         3'd3:    return "P";
         3'd4:    return "/";
         3'd5:    return "1";
         3'd6:    return ".";
         3'd7:    return "1";
         default: return 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] host_char(input logic [1:0] idx);
      case (idx)
         2'd0:    return "H";
         2'd1:    return "o";
         2'd2:    return "s";
         2'd3:    return "t";
         default: return 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] close_char(input logic [4:0] idx);
      case (idx)
         5'd0:    return "C";
         5'd1:    return "o";
         5'd2:    return "n";
         5'd3:    return "n";
         5'd4:    return "e";
         5'd5:    return "c";
         5'd6:    return "t";
         5'd7:    return "i";
         5'd8:    return "o";
         5'd9:    return "n";
         5'd10:   return ":";
         5'd11:   return " ";
         5'd12:   return "c";
         5'd13:   return "l";
         5'd14:   return "o";
         5'd15:   return "s";
         5'd16:   return "e";
         default: return 8'h00;
      endcase
   endfunction

endpackage

// ===== rtl/core/hgv_content.sv =====
// Parser update for one content byte of the request line or a header line.
module hgv_content #(
   parameter int URL_COUNT_WIDTH = 12
) (
   input  hgv_pkg::hdr_state_type     st_i,
   input  logic [URL_COUNT_WIDTH-1:0] cnt_i,
   input  logic [7:0]                 data_i,
   output hgv_pkg::hdr_state_type     st_o,
   output logic [URL_COUNT_WIDTH-1:0] cnt_o
);

   localparam logic [URL_COUNT_WIDTH-1:0] URL_MAX = '1;

   always_comb begin
      st_o  = st_i;
      cnt_o = cnt_i;
      if (st_i.line_number == 2'd0) begin
         case (st_i.phase)
            hgv_pkg::PH_METHOD: begin
               if (data_i == hgv_pkg::CHAR_SPACE) begin
                  if (st_i.literal_index == hgv_pkg::METHOD_LEN) begin
                     st_o.phase         = hgv_pkg::PH_URL;
                     st_o.literal_index = 4'd0;
                  end else begin
                     st_o.error_seen = 1'b1;
                     st_o.phase      = hgv_pkg::PH_SKIP;
                  end
               end else if (st_i.literal_index < hgv_pkg::METHOD_LEN &&
                            data_i == hgv_pkg::method_char(st_i.literal_index[1:0])) begin
                  st_o.literal_index = st_i.literal_index + 4'd1;
               end else begin
                  st_o.error_seen = 1'b1;
                  st_o.phase      = hgv_pkg::PH_SKIP;
               end
            end
            hgv_pkg::PH_URL: begin
               if (data_i == hgv_pkg::CHAR_SPACE) begin
                  if (cnt_i == '0) begin
                     st_o.error_seen = 1'b1;
                     st_o.phase      = hgv_pkg::PH_SKIP;
                  end else begin
                     st_o.phase         = hgv_pkg::PH_VERSION;
                     st_o.literal_index = 4'd0;
                  end
               end else begin
                  if (cnt_i == '0 && data_i != hgv_pkg::CHAR_SLASH) begin
                     st_o.error_seen = 1'b1;
                  end
                  if (cnt_i != URL_MAX) begin
                     cnt_o = cnt_i + URL_COUNT_WIDTH'(1);
                  end else begin
                     st_o.url_overflowed = 1'b1;
                  end
               end
            end
            hgv_pkg::PH_VERSION: begin
               if (st_i.literal_index < hgv_pkg::VERSION_LEN &&
                   data_i == hgv_pkg::version_char(st_i.literal_index[2:0])) begin
                  st_o.literal_index = st_i.literal_index + 4'd1;
               end else begin
                  st_o.error_seen = 1'b1;
                  st_o.phase      = hgv_pkg::PH_SKIP;
               end
            end
            default: begin
            end
         endcase
      end else begin
         if (st_i.line_number == 2'd1 && st_i.separator_progress < hgv_pkg::SEP_FOUND &&
             st_i.host_progress < hgv_pkg::HOST_LEN) begin
            if (data_i == hgv_pkg::host_char(st_i.host_progress[1:0])) begin
               st_o.host_progress = st_i.host_progress + 3'd1;
            end else begin
               st_o.host_progress = (data_i == hgv_pkg::CHAR_H) ? 3'd1 : 3'd0;
            end
         end
         case (st_i.separator_progress)
            hgv_pkg::SEP_COLON: begin
               if (data_i == hgv_pkg::CHAR_SPACE) begin
                  st_o.separator_progress = hgv_pkg::SEP_FOUND;
               end else begin
                  st_o.key_nonempty = 1'b1;
                  if (data_i != hgv_pkg::CHAR_COLON) begin
                     st_o.separator_progress = hgv_pkg::SEP_NONE;
                  end
               end
            end
            hgv_pkg::SEP_NONE: begin
               if (data_i == hgv_pkg::CHAR_COLON) begin
                  st_o.separator_progress = hgv_pkg::SEP_COLON;
               end else begin
                  st_o.key_nonempty = 1'b1;
               end
            end
            default: begin
               st_o.separator_progress = hgv_pkg::SEP_VALUE;
            end
         endcase
      end
   end

endmodule

// ===== rtl/core/hgv_byte_step.sv =====
// Full state update for one stream byte, with line and request end detection.
module hgv_byte_step #(
   parameter int URL_COUNT_WIDTH = 12
) (
   input  hgv_pkg::hdr_state_type     st_i,
   input  hgv_pkg::strm_state_type    strm_i,
   input  logic [URL_COUNT_WIDTH-1:0] cnt_i,
   input  logic [7:0]                 data_i,
   output hgv_pkg::hdr_state_type     st_o,
   output hgv_pkg::strm_state_type    strm_o,
   output logic [URL_COUNT_WIDTH-1:0] cnt_o,
   output logic                       end_o,
   output hgv_pkg::rsp_type           rsp_o
);

   localparam int CW = (URL_COUNT_WIDTH > 12) ? URL_COUNT_WIDTH : 12;

   hgv_pkg::hdr_state_type     st_a;
   hgv_pkg::hdr_state_type     st_b;
   hgv_pkg::hdr_state_type     st_p;
   logic [URL_COUNT_WIDTH-1:0] cnt_a;
   logic [URL_COUNT_WIDTH-1:0] cnt_b;
   logic [URL_COUNT_WIDTH-1:0] cnt_p;
   logic [7:0]                 data_a;
   logic                       is_cr;
   logic                       is_lf;
   logic                       req_end;
   logic [CW-1:0]              cnt_ext;
   logic                       cnt_big;

   assign is_cr   = (data_i == hgv_pkg::CHAR_CR);
   assign is_lf   = (data_i == hgv_pkg::CHAR_LF);
   assign req_end = (strm_i.terminator_progress == 2'd3) && is_lf;
   assign data_a  = strm_i.carriage_return_held ? hgv_pkg::CHAR_CR : data_i;

   // A held CR that turns out not to end a line is parsed as content first.
   hgv_content #(.URL_COUNT_WIDTH(URL_COUNT_WIDTH)) u_content_a (
      .st_i   (st_i),
      .cnt_i  (cnt_i),
      .data_i (data_a),
      .st_o   (st_a),
      .cnt_o  (cnt_a)
   );

   hgv_content #(.URL_COUNT_WIDTH(URL_COUNT_WIDTH)) u_content_b (
      .st_i   (st_a),
      .cnt_i  (cnt_a),
      .data_i (data_i),
      .st_o   (st_b),
      .cnt_o  (cnt_b)
   );

   always_comb begin
      strm_o = strm_i;
      if (!strm_i.close_found) begin
         if (strm_i.close_progress < hgv_pkg::CLOSE_LEN &&
             data_i == hgv_pkg::close_char(strm_i.close_progress)) begin
            if (strm_i.close_progress + 5'd1 == hgv_pkg::CLOSE_LEN) begin
               strm_o.close_found    = 1'b1;
               strm_o.close_progress = 5'd0;
            end else begin
               strm_o.close_progress = strm_i.close_progress + 5'd1;
            end
         end else begin
            strm_o.close_progress = (data_i == hgv_pkg::CHAR_C) ? 5'd1 : 5'd0;
         end
      end
      if (is_cr) begin
         strm_o.terminator_progress = (strm_i.terminator_progress == 2'd2) ? 2'd3 : 2'd1;
      end else if (is_lf && strm_i.terminator_progress == 2'd1) begin
         strm_o.terminator_progress = 2'd2;
      end else begin
         strm_o.terminator_progress = 2'd0;
      end

      st_p  = st_i;
      cnt_p = cnt_i;
      if (strm_i.carriage_return_held) begin
         if (is_lf) begin
            strm_o.carriage_return_held = 1'b0;
            if (!req_end) begin
               if (st_i.line_number == 2'd0) begin
                  if (st_i.phase == hgv_pkg::PH_URL) begin
                     st_p.error_seen     = 1'b1;
                     cnt_p               = '0;
                     st_p.url_overflowed = 1'b0;
                  end else if (st_i.phase == hgv_pkg::PH_METHOD) begin
                     st_p.error_seen = 1'b1;
                  end else if (st_i.phase == hgv_pkg::PH_VERSION &&
                               st_i.literal_index != hgv_pkg::VERSION_LEN) begin
                     st_p.error_seen = 1'b1;
                  end
               end else begin
                  if (!(st_i.separator_progress == hgv_pkg::SEP_VALUE && st_i.key_nonempty)) begin
                     st_p.error_seen = 1'b1;
                  end
                  if (st_i.line_number == 2'd1 && st_i.host_progress != hgv_pkg::HOST_LEN) begin
                     st_p.error_seen = 1'b1;
                  end
               end
               st_p.separator_progress = hgv_pkg::SEP_NONE;
               st_p.key_nonempty       = 1'b0;
               if (st_i.line_number < hgv_pkg::LINES_MIN) begin
                  st_p.line_number = st_i.line_number + 2'd1;
               end
            end
         end else if (is_cr) begin
            st_p  = st_a;
            cnt_p = cnt_a;
         end else begin
            strm_o.carriage_return_held = 1'b0;
            st_p  = st_b;
            cnt_p = cnt_b;
         end
      end else if (is_cr) begin
         strm_o.carriage_return_held = 1'b1;
      end else begin
         st_p  = st_a;
         cnt_p = cnt_a;
      end

      if (req_end) begin
         st_o   = hgv_pkg::HDR_CLEAR;
         strm_o = hgv_pkg::STRM_CLEAR;
         cnt_o  = '0;
      end else begin
         st_o  = st_p;
         cnt_o = cnt_p;
      end
   end

   assign cnt_ext = CW'(cnt_p);
   assign cnt_big = (cnt_ext > CW'(hgv_pkg::OUT_URL_MAX));
   assign end_o   = req_end;

   always_comb begin
      rsp_o.status          = st_p.error_seen || (st_p.line_number < hgv_pkg::LINES_MIN);
      rsp_o.close_requested = strm_i.close_found;
      rsp_o.url_length      = cnt_big ? hgv_pkg::OUT_URL_MAX : cnt_ext[11:0];
      rsp_o.url_overflow    = st_p.url_overflowed || cnt_big;
   end

endmodule

// ===== rtl/core/http_get_request_validator_unit.sv =====
// rsp_valid is registered after a terminating LF on req passes the input register.
// Throughput: one byte per cycle without req_stall, set by the state update loop.
// A stalled result holds only the bytes that would produce another result.
// Reset is synchronous and active high; it clears all parser state and the valid
// flags of both holding registers, after which the block accepts a byte at once.
// Top level of the request validator: input register, parser step, result register.
`include "http_get_request_validator_unit_macros.svh"

module http_get_request_validator_unit #(
   parameter int URL_COUNT_WIDTH = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_status,
   output logic        rsp_close_requested,
   output logic [11:0] rsp_url_length,
   output logic        rsp_url_overflow
);

   localparam logic [11:0] URL_LEN_TOP = 12'((1 << URL_COUNT_WIDTH) - 1);

   logic                       in_valid_ff;
   logic                       in_valid_in;
   logic [7:0]                 in_byte_ff;
   hgv_pkg::hdr_state_type     st_ff;
   hgv_pkg::hdr_state_type     st_in;
   hgv_pkg::strm_state_type    strm_ff;
   hgv_pkg::strm_state_type    strm_in;
   logic [URL_COUNT_WIDTH-1:0] cnt_ff;
   logic [URL_COUNT_WIDTH-1:0] cnt_in;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   hgv_pkg::rsp_type           rsp_ff;
   hgv_pkg::rsp_type           rsp_in;
   logic                       step_end;
   logic                       fire;

   hgv_byte_step #(.URL_COUNT_WIDTH(URL_COUNT_WIDTH)) u_byte_step (
      .st_i   (st_ff),
      .strm_i (strm_ff),
      .cnt_i  (cnt_ff),
      .data_i (in_byte_ff),
      .st_o   (st_in),
      .strm_o (strm_in),
      .cnt_o  (cnt_in),
      .end_o  (step_end),
      .rsp_o  (rsp_in)
   );

   // Only a byte that completes a request waits for the result register.
   assign fire         = in_valid_ff && !(step_end && rsp_valid_ff && rsp_stall);
   assign req_stall    = in_valid_ff && !fire;
   assign in_valid_in  = req_stall ? in_valid_ff : req_valid;
   assign rsp_valid_in = (fire && step_end) ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         st_ff        <= hgv_pkg::HDR_CLEAR;
         strm_ff      <= hgv_pkg::STRM_CLEAR;
         cnt_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            st_ff   <= st_in;
            strm_ff <= strm_in;
            cnt_ff  <= cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_data_byte;
      end
      if (fire && step_end) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_ff.status;
   assign rsp_close_requested = rsp_ff.close_requested;
   assign rsp_url_length      = rsp_ff.url_length;
   assign rsp_url_overflow    = rsp_ff.url_overflow;

   `HGV_ASSERT_IMPLIES(a_overflow_saturated, clock, reset, rsp_valid && rsp_url_overflow, rsp_url_length == URL_LEN_TOP)
   `HGV_ASSERT_NEXT(a_request_clears, clock, reset, fire && step_end, st_ff.line_number == 2'd0 && cnt_ff == '0 && !strm_ff.close_found)
   `HGV_ASSERT_IMPLIES(a_cr_held_in_terminator, clock, reset, strm_ff.terminator_progress[0], strm_ff.carriage_return_held)

endmodule
